@@ src/edb_pkg.sv @@
// Shared types, constants and helper functions of the deformation blend block.
package edb_pkg;

  typedef enum logic {
    KIND_LOAD      = 1'b0,
    KIND_INFLUENCE = 1'b1
  } kind_e;

  // Word layout of one node: position xyz, rotation column-major, translation xyz
  localparam logic [3:0] WSEL_ROT_FIRST = 4'd3;
  localparam logic [3:0] WSEL_TRN_X     = 4'd12;
  localparam logic [3:0] WSEL_UNUSED    = 4'd15;

  // Sequencer schedule, in steps of the run phase
  localparam logic [4:0] STEP_READ_LAST = 5'd14;
  localparam logic [4:0] STEP_A_FIRST   = 5'd1;
  localparam logic [4:0] STEP_A_LAST    = 5'd15;
  localparam logic [4:0] STEP_W_FIRST   = 5'd17;
  localparam logic [4:0] STEP_W_LAST    = 5'd19;
  localparam logic [4:0] STEP_DONE      = 5'd20;

  localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;

  typedef struct packed {
    kind_e              kind;
    logic [8:0]         node_index;
    logic [3:0]         word_select;
    logic signed [31:0] word_value;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [30:0]        weight;
    logic               last_influence;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } out_item_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic       start;
    logic       a_valid;
    logic [3:0] a_word;
    logic       w_valid;
    logic [1:0] w_idx;
    logic       clear;
  } dp_ctl_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_P_VAL  = 2'd1,
    OP_P_PROD = 2'd2,
    OP_SUM    = 2'd3
  } acc_op_e;

  typedef struct packed {
    logic [1:0] col;
    logic [1:0] row;
  } rc_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] val;
  } clip_t;

  // Rotation word 3+3*col+row holds R[row][col]
  function automatic rc_t rot_place(logic [3:0] word);
    rc_t rc;
    rc = '0;
    unique case (word)
      4'd3:    rc = '{col: 2'd0, row: 2'd0};
      4'd4:    rc = '{col: 2'd0, row: 2'd1};
      4'd5:    rc = '{col: 2'd0, row: 2'd2};
      4'd6:    rc = '{col: 2'd1, row: 2'd0};
      4'd7:    rc = '{col: 2'd1, row: 2'd1};
      4'd8:    rc = '{col: 2'd1, row: 2'd2};
      4'd9:    rc = '{col: 2'd2, row: 2'd0};
      4'd10:   rc = '{col: 2'd2, row: 2'd1};
      4'd11:   rc = '{col: 2'd2, row: 2'd2};
      default: rc = '0;
    endcase
    return rc;
  endfunction

  function automatic clip_t clip_word(logic signed [63:0] v);
    clip_t r;
    r.hit = 1'b0;
    r.val = v[31:0];
    if (v > Q_MAX64) begin
      r.hit = 1'b1;
      r.val = Q_MAX64[31:0];
    end else if (v < Q_MIN64) begin
      r.hit = 1'b1;
      r.val = Q_MIN64[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/edb_in_if.sv @@
// Input channel: node loads and vertex influences.
interface edb_in_if;
  import edb_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/edb_out_if.sv @@
// Output channel: deformed vertices.
interface edb_out_if;
  import edb_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/edb_node_mem.sv @@
// Node word store: one write port, one registered read port.
module edb_node_mem #(
  parameter int unsigned AW = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [2**AW];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/edb_blend_dp.sv @@
// Blend datapath: shared multiplier, point accumulators and vertex sums.
module edb_blend_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  edb_pkg::dp_ctl_t   ctl_i,
  input  logic signed [31:0] vertex_x_i,
  input  logic signed [31:0] vertex_y_i,
  input  logic signed [31:0] vertex_z_i,
  input  logic [30:0]        weight_i,
  input  logic               node_ok_i,
  input  logic [31:0]        rd_data_i,
  output edb_pkg::out_item_t result_o
);
  import edb_pkg::*;

  logic signed [31:0] v_q [3];
  logic [30:0]        w_q;
  logic               node_ok_q;
  logic signed [32:0] d_q [3];
  logic signed [35:0] p_q [3];
  logic signed [63:0] sum_q [3];
  logic               clip_q;
  logic signed [65:0] prod_q;
  acc_op_e            b_op_q;
  logic [1:0]         b_idx_q;
  logic signed [35:0] b_val_q;

  logic [31:0]        data;
  rc_t                place;
  logic               is_pos;
  logic               is_rot;
  logic signed [31:0] v_sel;
  logic signed [35:0] p_sel;
  clip_t              p_clip;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_d;
  logic signed [33:0] term;
  clip_t              c_x;
  clip_t              c_y;
  clip_t              c_z;

  // Unknown node index reads as an all-zero node
  assign data   = node_ok_q ? rd_data_i : '0;
  assign place  = rot_place(ctl_i.a_word);
  assign is_pos = ctl_i.a_word < WSEL_ROT_FIRST;
  assign is_rot = (ctl_i.a_word >= WSEL_ROT_FIRST) && (ctl_i.a_word < WSEL_TRN_X);
  assign v_sel  = v_q[ctl_i.a_word[1:0]];
  assign p_sel  = p_q[ctl_i.w_idx];
  assign p_clip = clip_word({{28{p_sel[35]}}, p_sel});

  always_comb begin
    if (ctl_i.w_valid) begin
      mul_a = {2'b00, w_q};
      mul_b = {p_clip.val[31], p_clip.val};
    end else begin
      mul_a = {data[31], data};
      mul_b = d_q[place.col];
    end
  end

  assign prod_d = mul_a * mul_b;
  // floor(prod / 2^30); products stay within 64 signed bits
  assign term   = prod_q[63:30];

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      v_q[0]    <= vertex_x_i;
      v_q[1]    <= vertex_y_i;
      v_q[2]    <= vertex_z_i;
      w_q       <= weight_i;
      node_ok_q <= node_ok_i;
    end
    if ((ctl_i.a_valid && is_rot) || ctl_i.w_valid) begin
      prod_q <= prod_d;
    end
    if (ctl_i.a_valid && is_pos) begin
      d_q[ctl_i.a_word[1:0]] <= {v_sel[31], v_sel} - {data[31], data};
    end
    if (ctl_i.a_valid) begin
      b_val_q <= {{4{data[31]}}, data};
      if (is_pos) begin
        b_idx_q <= ctl_i.a_word[1:0];
      end else if (is_rot) begin
        b_idx_q <= place.row;
      end else begin
        b_idx_q <= 2'(ctl_i.a_word - WSEL_TRN_X);
      end
    end else if (ctl_i.w_valid) begin
      b_idx_q <= ctl_i.w_idx;
    end
    for (int k = 0; k < 3; k++) begin
      if (ctl_i.start) begin
        p_q[k] <= '0;
      end else if (b_idx_q == 2'(k)) begin
        if (b_op_q == OP_P_VAL) begin
          p_q[k] <= p_q[k] + b_val_q;
        end else if (b_op_q == OP_P_PROD) begin
          p_q[k] <= p_q[k] + {{2{term[33]}}, term};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_op_q <= OP_NONE;
      clip_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      if (ctl_i.a_valid) begin
        b_op_q <= is_rot ? OP_P_PROD : OP_P_VAL;
      end else if (ctl_i.w_valid) begin
        b_op_q <= OP_SUM;
      end else begin
        b_op_q <= OP_NONE;
      end
      if (ctl_i.clear) begin
        clip_q <= 1'b0;
      end else if (ctl_i.w_valid && p_clip.hit) begin
        clip_q <= 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
        if (ctl_i.clear) begin
          sum_q[k] <= '0;
        end else if (b_op_q == OP_SUM && b_idx_q == 2'(k)) begin
          sum_q[k] <= sum_q[k] + {{30{term[33]}}, term};
        end
      end
    end
  end

  assign c_x = clip_word(sum_q[0]);
  assign c_y = clip_word(sum_q[1]);
  assign c_z = clip_word(sum_q[2]);

  assign result_o.out_x     = c_x.val;
  assign result_o.out_y     = c_y.val;
  assign result_o.out_z     = c_z.val;
  assign result_o.saturated = clip_q | c_x.hit | c_y.hit | c_z.hit;

endmodule

@@ src/edb_ctrl.sv @@
// Sequencer: handshake, node word reads and the multiply/accumulate schedule.
module edb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  edb_pkg::kind_e    in_kind_i,
  input  logic              in_last_i,
  input  logic              in_node_ok_i,
  input  logic [3:0]        in_wsel_i,
  input  logic              out_free_i,
  output logic              in_ready_o,
  output logic              mem_we_o,
  output logic              rd_en_o,
  output logic [3:0]        rd_word_o,
  output logic              emit_o,
  output edb_pkg::dp_ctl_t  ctl_o
);
  import edb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       last_q;
  logic       accept;
  logic       start;
  logic       running;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign start      = accept && (in_kind_i == KIND_INFLUENCE);
  assign mem_we_o   = accept && (in_kind_i == KIND_LOAD) && in_node_ok_i &&
                      (in_wsel_i != WSEL_UNUSED);
  assign running    = (state_q == ST_RUN);

  assign rd_en_o   = running && (step_q <= STEP_READ_LAST);
  assign rd_word_o = step_q[3:0];
  assign emit_o    = (state_q == ST_FIN) && last_q && out_free_i;

  assign ctl_o.start   = start;
  assign ctl_o.a_valid = running && (step_q >= STEP_A_FIRST) && (step_q <= STEP_A_LAST);
  assign ctl_o.a_word  = 4'(step_q - STEP_A_FIRST);
  assign ctl_o.w_valid = running && (step_q >= STEP_W_FIRST) && (step_q <= STEP_W_LAST);
  assign ctl_o.w_idx   = 2'(step_q - STEP_W_FIRST);
  assign ctl_o.clear   = emit_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_DONE) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      ST_FIN: begin
        // a final influence waits for the output register
        if (!last_q || out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (start) begin
        last_q <= in_last_i;
      end
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_RUN) && (step_q == 5'd0))
    else $error("influence did not start the run at step zero");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running |-> (step_q <= STEP_DONE))
    else $error("step counter ran past the schedule");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.a_valid && ctl_o.w_valid))
    else $error("node and weight phases share the multiplier");

  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |=> (state_q == ST_IDLE) && in_ready_o)
    else $error("block not idle after emitting a vertex");

endmodule

@@ src/embedded_deformation_blend.sv @@
// Embedded deformation blend: top level with node store, sequencer and output register.
// A load transfer writes one 32-bit node word. An influence transfer runs to its end before
// the next item is accepted: 15 node words are read one per cycle through the single read
// port of the node store, nine rotation products and three weight products go through one
// shared 33x33 multiplier, and each registered weight product is then added into the
// vertex sums. The deformed vertex is held in an output register, so the block takes new
// items while a result waits; a final influence waits only when that register is still
// full. The node store holds 16 words per node and needs no clearing after reset.
module embedded_deformation_blend #(
  parameter int unsigned NODE_COUNT = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  edb_in_if.sink           in_i,
  edb_out_if.source        out_o
);
  import edb_pkg::*;

  localparam int unsigned NodeAw = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned MemAw  = NodeAw + 4;

  logic              node_ok;
  logic [NodeAw-1:0] node_addr;
  logic [NodeAw-1:0] node_addr_q;
  logic              out_free;
  logic              mem_we;
  logic              rd_en;
  logic [3:0]        rd_word;
  logic [31:0]       rd_data;
  logic              emit;
  dp_ctl_t           ctl;
  out_item_t         result;
  logic              out_valid_q;
  out_item_t         out_data_q;

  assign node_ok   = {23'd0, in_i.data.node_index} < 32'(NODE_COUNT);
  assign node_addr = NodeAw'(in_i.data.node_index);
  assign out_free  = !out_valid_q || out_o.ready;

  edb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_kind_i    (in_i.data.kind),
    .in_last_i    (in_i.data.last_influence),
    .in_node_ok_i (node_ok),
    .in_wsel_i    (in_i.data.word_select),
    .out_free_i   (out_free),
    .in_ready_o   (in_i.ready),
    .mem_we_o     (mem_we),
    .rd_en_o      (rd_en),
    .rd_word_o    (rd_word),
    .emit_o       (emit),
    .ctl_o        (ctl)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.start) begin
      node_addr_q <= node_addr;
    end
  end

  edb_node_mem #(
    .AW (MemAw)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({node_addr, in_i.data.word_select}),
    .wdata_i (in_i.data.word_value),
    .re_i    (rd_en),
    .raddr_i ({node_addr_q, rd_word}),
    .rdata_o (rd_data)
  );

  edb_blend_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .vertex_x_i (in_i.data.vertex_x),
    .vertex_y_i (in_i.data.vertex_y),
    .vertex_z_i (in_i.data.vertex_z),
    .weight_i   (in_i.data.weight),
    .node_ok_i  (node_ok),
    .rd_data_i  (rd_data),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

@@ tb/tb_embedded_deformation_blend.sv @@
// Testbench for the deformation blend block: node loads, vertex influences, vertex checks.
module tb_embedded_deformation_blend;
  import edb_pkg::*;

  localparam int unsigned NODES       = 512;
  localparam int unsigned ITEM_TARGET = 1300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Node with extreme words: position, rotation column-major, translation
  localparam logic [31:0] EXTREME_NODE [15] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
    32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h4000_0000,
    32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000
  };

  class skin_scoreboard;
    logic [31:0]        pos_tab [NODES*3];
    logic [31:0]        rot_tab [NODES*9];
    logic [31:0]        trn_tab [NODES*3];
    logic signed [63:0] acc [3];
    bit                 clip_seen;
    out_item_t          deformed_q [$];
    int unsigned        failures;

    function new();
      foreach (pos_tab[k]) pos_tab[k] = '0;
      foreach (rot_tab[k]) rot_tab[k] = '0;
      foreach (trn_tab[k]) trn_tab[k] = '0;
      foreach (acc[k]) acc[k] = '0;
      clip_seen = 1'b0;
      failures  = 0;
    endfunction

    function logic signed [31:0] clamp(logic signed [65:0] x);
      if (x > 66'sd2147483647) begin
        clip_seen = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (x < -66'sd2147483648) begin
        clip_seen = 1'b1;
        return 32'sh8000_0000;
      end
      return x[31:0];
    endfunction

    // Applies one accepted transfer to the node store and the vertex sums
    function void take_item(in_item_t item);
      logic signed [65:0] g [3];
      logic signed [65:0] t [3];
      logic signed [65:0] r [9];
      logic signed [65:0] v [3];
      logic signed [65:0] w, p, q;
      int unsigned        n, sel, i, j;
      out_item_t          res;
      n   = 32'(item.node_index);
      sel = 32'(item.word_select);
      if (item.kind == KIND_LOAD) begin
        if (n < NODES) begin
          if (item.word_select < WSEL_ROT_FIRST)
            pos_tab[n*3 + sel] = item.word_value;
          else if (item.word_select < WSEL_TRN_X)
            rot_tab[n*9 + sel - WSEL_ROT_FIRST] = item.word_value;
          else if (item.word_select < WSEL_UNUSED)
            trn_tab[n*3 + sel - WSEL_TRN_X] = item.word_value;
        end
        return;
      end
      for (i = 0; i < 3; i++) begin
        g[i] = '0;
        t[i] = '0;
      end
      for (i = 0; i < 9; i++) r[i] = '0;
      if (n < NODES) begin
        for (i = 0; i < 3; i++) begin
          g[i] = 66'($signed(pos_tab[n*3 + i]));
          t[i] = 66'($signed(trn_tab[n*3 + i]));
        end
        for (i = 0; i < 9; i++) r[i] = 66'($signed(rot_tab[n*9 + i]));
      end
      v[0] = 66'(item.vertex_x);
      v[1] = 66'(item.vertex_y);
      v[2] = 66'(item.vertex_z);
      w    = $signed({35'd0, item.weight});
      for (i = 0; i < 3; i++) begin
        p = g[i] + t[i];
        for (j = 0; j < 3; j++) p += (r[3*j + i] * (v[j] - g[j])) >>> 30;
        p = 66'(clamp(p));
        q = (w * p) >>> 30;
        acc[i] = acc[i] + q[63:0];
      end
      if (!item.last_influence) return;
      res.out_x     = clamp(66'(acc[0]));
      res.out_y     = clamp(66'(acc[1]));
      res.out_z     = clamp(66'(acc[2]));
      res.saturated = clip_seen;
      deformed_q = {deformed_q, res};
      foreach (acc[k]) acc[k] = '0;
      clip_seen = 1'b0;
    endfunction

    function void check_vertex(out_item_t got);
      out_item_t want;
      if (deformed_q.size() == 0) begin
        if (failures < 10)
          $display("unexpected vertex x=%0d y=%0d z=%0d sat=%0b",
                   got.out_x, got.out_y, got.out_z, got.saturated);
        failures++;
        return;
      end
      want = deformed_q.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.saturated !== want.saturated) begin
        if (failures < 10)
          $display("vertex mismatch: expected x=%0d y=%0d z=%0d sat=%0b,",
                   want.out_x, want.out_y, want.out_z, want.saturated,
                   " got x=%0d y=%0d z=%0d sat=%0b",
                   got.out_x, got.out_y, got.out_z, got.saturated);
        failures++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  bit             steady;
  int unsigned    sent;
  bit [14:0]      word_mask [NODES];
  int unsigned    live_nodes [$];
  skin_scoreboard board = new();

  edb_in_if  in_ch ();
  edb_out_if out_ch ();

  embedded_deformation_blend #(.NODE_COUNT(NODES)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] coord_value();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return int'($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] rot_value();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom();
      3:       return 32'h4000_0000;
      default: return int'($urandom_range(32'h7fff_ffff)) - 32'sh4000_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_weight();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 31'h7fff_ffff;
      2:       return 31'h4000_0000;
      3:       return 31'($urandom());
      default: return 31'($urandom_range(32'h4000_0000));
    endcase
  endfunction

  function automatic logic [31:0] word_for(int unsigned sel);
    if (sel >= WSEL_ROT_FIRST && sel < WSEL_TRN_X) return rot_value();
    return coord_value();
  endfunction

  function automatic in_item_t make_load(int unsigned n, int unsigned sel, logic [31:0] value);
    in_item_t item;
    item             = '0;
    item.kind        = KIND_LOAD;
    item.node_index  = 9'(n);
    item.word_select = 4'(sel);
    item.word_value  = value;
    return item;
  endfunction

  function automatic in_item_t make_influence(int unsigned n, logic [31:0] vx, logic [31:0] vy,
                                              logic [31:0] vz, logic [30:0] wt, bit last);
    in_item_t item;
    item                = '0;
    item.kind           = KIND_INFLUENCE;
    item.node_index     = 9'(n);
    item.vertex_x       = vx;
    item.vertex_y       = vy;
    item.vertex_z       = vz;
    item.weight         = wt;
    item.last_influence = last;
    return item;
  endfunction

  // Offers one item, with random idle cycles ahead of it, and waits for the transfer
  task automatic push_item(input in_item_t item);
    int unsigned n;
    n = 32'(item.node_index);
    while (!steady && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    board.take_item(item);
    if (item.kind == KIND_INFLUENCE) begin
      sent++;
    end else if (item.word_select != WSEL_UNUSED) begin
      sent++;
      if (word_mask[n] != 15'h7fff) begin
        word_mask[n][item.word_select] = 1'b1;
        if (word_mask[n] == 15'h7fff) live_nodes = {live_nodes, n};
      end
    end
  endtask

  // Writes all words of a node in shuffled order
  task automatic load_node(input int unsigned n);
    int unsigned order [15];
    int unsigned k, m, tmp;
    for (k = 0; k < 15; k++) order[k] = k;
    for (k = 14; k > 0; k--) begin
      m        = $urandom_range(k);
      tmp      = order[k];
      order[k] = order[m];
      order[m] = tmp;
    end
    for (k = 0; k < 15; k++) push_item(make_load(n, order[k], word_for(order[k])));
  endtask

  task automatic vertex_group();
    int unsigned k, m, n;
    logic [31:0] vx, vy, vz;
    logic [30:0] wt;
    bit          shared, broken;
    k      = $urandom_range(4, 1);
    shared = $urandom_range(7) != 0;
    broken = $urandom_range(9) == 0;
    vx     = coord_value();
    vy     = coord_value();
    vz     = coord_value();
    for (m = 0; m < k; m++) begin
      if (!shared) begin
        vx = coord_value();
        vy = coord_value();
        vz = coord_value();
      end
      n  = live_nodes[$urandom_range(live_nodes.size() - 1)];
      wt = ($urandom_range(3) == 0) ? rand_weight() : 31'($urandom_range(32'h4000_0000) / k);
      push_item(make_influence(n, vx, vy, vz, wt, (m == k - 1) && !broken));
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) board.check_vertex(out_ch.data);
      out_ch.ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_item_t    item;
    int unsigned k, pick, sel;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    steady      = 1'b0;
    sent        = 0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    foreach (word_mask[n]) word_mask[n] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme node, ignored words, huge and zero weights
    for (k = 0; k < 15; k++) push_item(make_load(NODES - 1, k, EXTREME_NODE[k]));
    push_item(make_load(NODES - 1, WSEL_UNUSED, 32'hdead_beef));
    item = make_load(NODES - 1, WSEL_UNUSED - 1, 32'h0002_0000);
    item.last_influence = 1'b1;
    push_item(item);
    push_item(make_influence(NODES - 1, 32'h0, 32'h0, 32'h0, 31'h0, 1'b0));
    push_item(make_influence(NODES - 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
                             31'h4000_0000, 1'b0));
    push_item(make_influence(NODES - 1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                             31'h7fff_ffff, 1'b1));
    push_item(make_influence(NODES - 1, 32'h0001_0000, 32'hffff_0000, 32'h0003_8000,
                             31'h4000_0000, 1'b1));
    push_item(make_influence(NODES - 1, 32'h0, 32'h0, 32'h0, 31'h0, 1'b1));

    // Random: a pool of loaded nodes, then mostly vertex groups
    repeat (16) load_node($urandom_range(NODES - 1));
    while (sent < ITEM_TARGET) begin
      steady = (sent >= 500 && sent < 720);
      pick   = $urandom_range(99);
      if (pick < 6) begin
        load_node($urandom_range(NODES - 1));
      end else if (pick < 14) begin
        sel = $urandom_range(WSEL_UNUSED - 1);
        push_item(make_load($urandom_range(NODES - 1), sel, word_for(sel)));
      end else if (pick < 18) begin
        item = make_load($urandom_range(NODES - 1), $urandom_range(WSEL_UNUSED), $urandom());
        item.last_influence = 1'($urandom_range(1));
        push_item(item);
      end else begin
        vertex_group();
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (board.deformed_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.failures == 0 && board.deformed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
